[hw/rtl/pev_pkg.sv]
// ----------------------------------------------------------------------------
// pev_pkg
// Shared types and constants of the postfix expression evaluator.
// ----------------------------------------------------------------------------
package pev_pkg;

    localparam int WORD_W   = 32;
    localparam int SYM_W    = 8;
    localparam int STATUS_W = 3;

    // Symbol codes
    localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [SYM_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [SYM_W-1:0] CH_ZERO  = 8'h30;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DIV0  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_UNDER = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OVER  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd4;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV
    } alu_op_t;

    typedef enum logic [2:0] {
        PEV_IDLE,
        PEV_RD_LEFT,
        PEV_EXEC,
        PEV_WAIT_ALU,
        PEV_TERM_OUT
    } pev_state_t;

    // Request to the shared arithmetic unit
    typedef struct packed {
        logic              start;
        alu_op_t           op;
        logic [WORD_W-1:0] lhs;
        logic [WORD_W-1:0] rhs;
    } alu_req_t;

    // Response from the shared arithmetic unit
    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] result;
    } alu_rsp_t;

endpackage

[hw/rtl/postfix_expression_evaluator_core.sv]
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_core
// Evaluates postfix expressions fed one symbol per request on a stack.
// ----------------------------------------------------------------------------
// Input channel s_*: s_tdata[7:0] is the symbol byte, s_tlast marks the
// terminator, which ends the expression (its symbol is ignored).
// '+', '-', '*', '/' pop right then left and push left op right; any other
// byte pushes its value minus 48.
// Output channel m_*: one request per terminator, m_tdata[31:0] is the top
// of stack (zero when empty), m_tuser[2:0] the status (ok, divide by zero,
// underflow, overflow, empty stack).
// Per request: a push or an ignored symbol is taken in the idle state; +, -
// and * read the stack twice, run the ALU and write back; / runs the 32 steps
// of the shared divider instead (unless the divisor is zero). A terminator
// reads the top of stack, then waits until the output register is free.
// s_tready is low while an operator or terminator is in progress.
// A new symbol is taken while a result waits in the output register; a
// terminator holds until that register is free.
// After an error the rest of the expression is ignored until the terminator.
// Reset empties the stack, clears the error and drops m_tvalid; the stack
// storage itself needs no clearing pass.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator_core
    import pev_pkg::*;
#(
    parameter int STACK_DEPTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] symbol
    input  logic        s_tlast,   // terminator
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] value
    output logic [2:0]  m_tuser    // [2:0] status
);

    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);

    pev_state_t          state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                aborted_reg, aborted_next;
    logic [STATUS_W-1:0] err_reg, err_next;
    alu_op_t             op_reg, op_next;
    logic [WORD_W-1:0]   right_reg, right_next;

    logic                m_tvalid_reg;
    logic [WORD_W-1:0]   m_value_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic                out_load;

    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [WORD_W-1:0]   mem_wdata;
    logic                mem_re;
    logic [ADDR_W-1:0]   mem_raddr;
    logic [WORD_W-1:0]   mem_rdata;

    alu_req_t            alu_req;
    alu_rsp_t            alu_rsp;

    logic [CNT_W-1:0]    cnt_m1;
    logic [CNT_W-1:0]    cnt_m2;
    logic                is_op;
    alu_op_t             sym_op;
    logic [WORD_W-1:0]   push_val;

    assign cnt_m1   = count_reg - CNT_W'(1);
    assign cnt_m2   = count_reg - CNT_W'(2);
    assign push_val = {{(WORD_W-SYM_W){1'b0}}, s_tdata} - {{(WORD_W-SYM_W){1'b0}}, CH_ZERO};

    // Operator decode
    always_comb begin
        is_op  = 1'b1;
        sym_op = ALU_ADD;
        case (s_tdata)
            CH_PLUS:  sym_op = ALU_ADD;
            CH_MINUS: sym_op = ALU_SUB;
            CH_STAR:  sym_op = ALU_MUL;
            CH_SLASH: sym_op = ALU_DIV;
            default:  is_op  = 1'b0;
        endcase
    end

    pev_stack #(
        .DEPTH  (STACK_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_stack (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    pev_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .rsp     (alu_rsp)
    );

    // Sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= PEV_IDLE;
            count_reg   <= '0;
            aborted_reg <= 1'b0;
            err_reg     <= ST_OK;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            aborted_reg <= aborted_next;
            err_reg     <= err_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg    <= op_next;
        right_reg <= right_next;
    end

    // Next state, stack and ALU control
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        aborted_next = aborted_reg;
        err_next     = err_reg;
        op_next      = op_reg;
        right_next   = right_reg;
        s_tready     = 1'b0;
        out_load     = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = count_reg[ADDR_W-1:0];
        mem_wdata    = push_val;
        mem_re       = 1'b0;
        mem_raddr    = cnt_m1[ADDR_W-1:0];
        alu_req      = '0;
        alu_req.op   = op_reg;
        alu_req.lhs  = mem_rdata;
        alu_req.rhs  = right_reg;

        case (state_reg)
            PEV_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_tlast) begin
                        mem_re     = (count_reg != '0);
                        state_next = PEV_TERM_OUT;
                    end else if (!aborted_reg) begin
                        if (is_op) begin
                            if (count_reg < CNT_W'(2)) begin
                                aborted_next = 1'b1;
                                err_next     = ST_UNDER;
                            end else begin
                                op_next    = sym_op;
                                mem_re     = 1'b1;
                                state_next = PEV_RD_LEFT;
                            end
                        end else if (count_reg >= CNT_W'(STACK_DEPTH)) begin
                            aborted_next = 1'b1;
                            err_next     = ST_OVER;
                        end else begin
                            mem_we     = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                end
            end
            PEV_RD_LEFT: begin
                right_next = mem_rdata;
                mem_re     = 1'b1;
                mem_raddr  = cnt_m2[ADDR_W-1:0];
                state_next = PEV_EXEC;
            end
            PEV_EXEC: begin
                count_next = cnt_m2;
                if (op_reg == ALU_DIV && right_reg == '0) begin
                    aborted_next = 1'b1;
                    err_next     = ST_DIV0;
                    state_next   = PEV_IDLE;
                end else begin
                    alu_req.start = 1'b1;
                    state_next    = PEV_WAIT_ALU;
                end
            end
            PEV_WAIT_ALU: begin
                if (alu_rsp.done) begin
                    mem_we     = 1'b1;
                    mem_wdata  = alu_rsp.result;
                    count_next = count_reg + CNT_W'(1);
                    state_next = PEV_IDLE;
                end
            end
            PEV_TERM_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load     = 1'b1;
                    count_next   = '0;
                    aborted_next = 1'b0;
                    err_next     = ST_OK;
                    state_next   = PEV_IDLE;
                end
            end
            default: begin
                state_next = PEV_IDLE;
            end
        endcase
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_value_reg <= (count_reg != '0) ? mem_rdata : '0;
            if (aborted_reg) begin
                m_status_reg <= err_reg;
            end else if (count_reg == '0) begin
                m_status_reg <= ST_EMPTY;
            end else begin
                m_status_reg <= ST_OK;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_value_reg;
    assign m_tuser  = m_status_reg;

endmodule

[hw/rtl/pev_alu.sv]
// ----------------------------------------------------------------------------
// pev_alu
// Shared arithmetic unit: add, subtract and multiply with a registered result,
// signed division truncating toward zero over 32 restoring steps.
// ----------------------------------------------------------------------------
module pev_alu
    import pev_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic              busy_reg;
    logic              done_reg;
    logic [4:0]        iter_reg;
    logic [WORD_W-1:0] result_reg;
    logic [WORD_W-1:0] quo_reg;    // dividend shifting out, quotient shifting in
    logic [WORD_W-1:0] rem_reg;
    logic [WORD_W-1:0] den_reg;
    logic              neg_reg;

    logic [WORD_W-1:0] mag_l;
    logic [WORD_W-1:0] mag_r;
    logic [WORD_W:0]   rem_sh;
    logic [WORD_W:0]   rem_sub;
    logic              q_bit;
    logic [WORD_W-1:0] quo_step;
    logic [WORD_W-1:0] mul_lo;

    // Operand magnitudes for division
    assign mag_l = req.lhs[WORD_W-1] ? (~req.lhs + WORD_W'(1)) : req.lhs;
    assign mag_r = req.rhs[WORD_W-1] ? (~req.rhs + WORD_W'(1)) : req.rhs;

    // One restoring division step
    assign rem_sh   = {rem_reg, quo_reg[WORD_W-1]};
    assign rem_sub  = rem_sh - {1'b0, den_reg};
    assign q_bit    = ~rem_sub[WORD_W];
    assign quo_step = {quo_reg[WORD_W-2:0], q_bit};

    // Low word of the product
    assign mul_lo = req.lhs * req.rhs;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                case (req.op)
                    ALU_ADD: begin
                        result_reg <= req.lhs + req.rhs;
                        done_reg   <= 1'b1;
                    end
                    ALU_SUB: begin
                        result_reg <= req.lhs - req.rhs;
                        done_reg   <= 1'b1;
                    end
                    ALU_MUL: begin
                        result_reg <= mul_lo;
                        done_reg   <= 1'b1;
                    end
                    default: begin
                        busy_reg <= 1'b1;
                        iter_reg <= '0;
                        quo_reg  <= mag_l;
                        rem_reg  <= '0;
                        den_reg  <= mag_r;
                        neg_reg  <= req.lhs[WORD_W-1] ^ req.rhs[WORD_W-1];
                    end
                endcase
            end else if (busy_reg) begin
                quo_reg  <= quo_step;
                rem_reg  <= q_bit ? rem_sub[WORD_W-1:0] : rem_sh[WORD_W-1:0];
                iter_reg <= iter_reg + 5'd1;
                // last step: apply the sign
                if (iter_reg == 5'd31) begin
                    busy_reg   <= 1'b0;
                    done_reg   <= 1'b1;
                    result_reg <= neg_reg ? (~quo_step + WORD_W'(1)) : quo_step;
                end
            end
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = result_reg;

endmodule

[hw/rtl/pev_stack.sv]
// ----------------------------------------------------------------------------
// pev_stack
// Operand stack storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pev_stack
    import pev_pkg::*;
#(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WORD_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WORD_W-1:0] rdata
);

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data holds until the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/pev_checker.sv]
// ----------------------------------------------------------------------------
// pev_checker
// Port-level checks of the postfix expression evaluator, bound to the core.
// ----------------------------------------------------------------------------
module pev_checker
    import pev_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [2:0]  m_tuser
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Status code stays within its defined codes
    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser <= ST_EMPTY))
        else $error("undefined status code");

    // Empty stack reports a zero value
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_EMPTY |-> m_tdata == '0)
        else $error("empty stack with nonzero value");

    // A terminator request blocks the input for the following cycle
    a_term_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input ready right after terminator");

    // No result right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind postfix_expression_evaluator_core pev_checker u_pev_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[bench/postfix_expression_evaluator_core_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_core_test
// Self-checking bench for the postfix evaluator: directed expressions for
// every operator, error and stack limit, then random postfix expressions,
// first with random gaps on both channels and then back to back, each result
// checked against a local evaluator of the same expressions.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator_core_test;
    import pev_pkg::*;

    localparam int STACK_DEPTH = 32;
    localparam int STALL_LIMIT = 2000;
    localparam int TARGET_ITEMS = 1600;

    typedef struct {
        logic [WORD_W-1:0]   value;
        logic [STATUS_W-1:0] status;
    } answer_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata = '0;
    logic              s_tlast = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [31:0]       m_tdata;
    logic [2:0]        m_tuser;

    // local evaluator state
    logic [WORD_W-1:0]   calc_stack [STACK_DEPTH];
    int                  calc_depth = 0;
    bit                  calc_halted = 1'b0;
    logic [STATUS_W-1:0] calc_err = ST_OK;

    answer_t pending_answers[$];
    int      fail_count = 0;
    int      sent_items = 0;
    int      idle_cycles = 0;
    int      stall_left = 0;
    bit      gaps_on = 1'b1;

    postfix_expression_evaluator_core #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic bit is_operator(input logic [7:0] sym);
        return sym == CH_PLUS || sym == CH_MINUS || sym == CH_STAR || sym == CH_SLASH;
    endfunction

    function automatic logic [7:0] random_operand();
        logic [7:0] b;
        if ($urandom_range(0, 9) < 7)
            return CH_ZERO + 8'($urandom_range(0, 9));
        b = 8'($urandom_range(0, 255));
        while (is_operator(b))
            b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    function automatic logic [7:0] random_operator();
        case ($urandom_range(0, 3))
            0: return CH_PLUS;
            1: return CH_MINUS;
            2: return CH_STAR;
            default: return CH_SLASH;
        endcase
    endfunction

    // Evaluate one accepted request; a terminator queues the expected answer
    task automatic rpn_evaluate(input logic [7:0] sym, input logic term);
        answer_t           ans;
        logic [WORD_W-1:0] lhs;
        logic [WORD_W-1:0] rhs;
        logic [WORD_W-1:0] res;
        longint            quo;
        if (term) begin
            ans.value = (calc_depth > 0) ? calc_stack[calc_depth-1] : '0;
            if (calc_halted)
                ans.status = calc_err;
            else if (calc_depth == 0)
                ans.status = ST_EMPTY;
            else
                ans.status = ST_OK;
            pending_answers.push_back(ans);
            calc_depth = 0;
            calc_halted = 1'b0;
            calc_err = ST_OK;
        end else if (!calc_halted) begin
            if (!is_operator(sym)) begin
                if (calc_depth >= STACK_DEPTH) begin
                    calc_halted = 1'b1;
                    calc_err = ST_OVER;
                end else begin
                    calc_stack[calc_depth] = {24'd0, sym} - {24'd0, CH_ZERO};
                    calc_depth++;
                end
            end else if (calc_depth < 2) begin
                calc_halted = 1'b1;
                calc_err = ST_UNDER;
            end else begin
                rhs = calc_stack[calc_depth-1];
                lhs = calc_stack[calc_depth-2];
                calc_depth -= 2;
                res = '0;
                case (sym)
                    CH_PLUS:  res = lhs + rhs;
                    CH_MINUS: res = lhs - rhs;
                    CH_STAR:  res = lhs * rhs;
                    default: begin
                        if (rhs == '0) begin
                            calc_halted = 1'b1;
                            calc_err = ST_DIV0;
                        end else begin
                            // 64-bit quotient so most-negative / -1 wraps cleanly
                            quo = longint'(signed'(lhs)) / longint'(signed'(rhs));
                            res = quo[WORD_W-1:0];
                        end
                    end
                endcase
                if (!calc_halted) begin
                    calc_stack[calc_depth] = res;
                    calc_depth++;
                end
            end
        end
    endtask

    // Send one request, with an optional gap first
    task automatic send_item(input logic [7:0] sym, input logic term);
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sym;
        s_tlast  <= term;
        do @(posedge aclk); while (!s_tready);
        rpn_evaluate(sym, term);
        sent_items++;
    endtask

    // Symbols of a string, then a terminator with a random symbol byte
    task automatic send_expr(input string text);
        int i;
        for (i = 0; i < text.len(); i++)
            send_item(text[i], 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // Random postfix expression; long ones can reach the stack limit
    task automatic send_random_expr();
        int len;
        int depth;
        int n;
        case ($urandom_range(0, 19))
            0:       len = $urandom_range(30, 40);
            1, 2:    len = $urandom_range(13, 30);
            default: len = $urandom_range(1, 12);
        endcase
        depth = 0;
        for (n = 0; n < len; n++) begin
            if (depth >= 2 && $urandom_range(0, 99) < 45) begin
                send_item(random_operator(), 1'b0);
                depth--;
            end else begin
                send_item(random_operand(), 1'b0);
                depth++;
            end
        end
        while (depth > 1 && $urandom_range(0, 3) != 0) begin
            send_item(random_operator(), 1'b0);
            depth--;
        end
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic test_operators();
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(CH_PLUS, 1'b0);
        send_item(8'hFF, 1'b1);
        send_expr("34+");
        send_expr("92-");
        send_expr("76*");
        send_expr("83/");
        send_expr("07-2/");
        send_expr("");
    endtask

    task automatic test_errors();
        send_expr("50/");
        send_expr("450/");
        send_expr("+");
        send_expr("3*");
        send_expr("40/55+");
    endtask

    task automatic test_stack_limits();
        int n;
        // exactly full, then one push too many with more symbols after it
        for (n = 0; n < STACK_DEPTH; n++)
            send_item(random_operand(), 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b1);
        for (n = 0; n < STACK_DEPTH + 3; n++)
            send_item(random_operand(), 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic test_wrap();
        int n;
        // 128 * 16^6 = 2^31, the most negative word; then divide by -1
        send_item(8'hB0, 1'b0);
        for (n = 0; n < 6; n++) begin
            send_item(8'h40, 1'b0);
            send_item(CH_STAR, 1'b0);
        end
        send_item(CH_ZERO, 1'b0);
        send_item(CH_ZERO + 8'd1, 1'b0);
        send_item(CH_MINUS, 1'b0);
        send_item(CH_SLASH, 1'b0);
        send_item(8'h00, 1'b1);
    endtask

    task automatic test_random(input int upto);
        int n;
        while (sent_items < upto) begin
            if ($urandom_range(0, 9) == 0) begin
                // noise: any byte, frequent terminators
                for (n = $urandom_range(1, 8); n > 0; n--)
                    send_item(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            end else begin
                send_random_expr();
            end
        end
    endtask

    task automatic test_back_to_back();
        gaps_on = 1'b0;
        test_random(TARGET_ITEMS);
    endtask

    // Result checker
    always @(posedge aclk) begin : check_result
        answer_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_answers.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result: value=%h status=%0d", m_tdata, m_tuser);
            end else begin
                want = pending_answers.pop_front();
                if (m_tdata !== want.value || m_tuser !== want.status) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch: value exp %h got %h, status exp %0d got %0d",
                                 want.value, m_tdata, want.status, m_tuser);
                end
            end
        end
    end

    // Receiver stalls in random bursts while gaps are on
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (gaps_on && $urandom_range(0, 7) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 17);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog on cycles without any request moving
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_operators();
        test_errors();
        test_stack_limits();
        test_wrap();
        test_random(TARGET_ITEMS * 3 / 4);
        test_back_to_back();
        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (fail_count == 0 && pending_answers.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
